@@ rtl/assert_macros.svh @@
// assertion helpers, expect clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RAU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
	localparam int OPERAND_WIDTH = 16;
	localparam int OPR_W = OPERAND_WIDTH + 1;
	localparam int MAG_W = 2 * OPERAND_WIDTH;
	localparam int RED_W = MAG_W + 1;
	localparam int PROD_W = 2 * OPR_W;
	localparam int CNT_W = $clog2(MAG_W + 1);
	localparam int NUM_W = 33;
	localparam int DEN_W = 31;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_EQ  = 3'd4;
	localparam logic [2:0] CMD_GT  = 3'd5;
	localparam logic [2:0] CMD_LT  = 3'd6;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	localparam logic [1:0] SRC_A = 2'd0;
	localparam logic [1:0] SRC_B = 2'd1;
	localparam logic [1:0] SRC_R = 2'd2;

	typedef struct packed {
		logic       load_in;
		logic       red_load;
		logic       gcd_step;
		logic       div_init;
		logic       div_step;
		logic       red_store;
		logic       mul;
		logic       comb;
		logic [1:0] src;
	} rau_cmd_t;

	typedef struct packed {
		logic zero_den;
		logic gcd_done;
		logic div_last;
		logic arith;
	} rau_stat_t;
endpackage
`default_nettype wire

@@ rtl/rau_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               out_free,
	input  wire rau_pkg::rau_stat_t stat,
	output rau_pkg::rau_cmd_t       c,
	output logic                    in_ready,
	output logic                    out_load
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_RLOAD = 4'd2;
	localparam logic [3:0] S_GCD   = 4'd3;
	localparam logic [3:0] S_DINIT = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_STORE = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_COMB  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] src_q, src_d;

	always_comb begin
		state_d = state_q;
		src_d = src_q;
		c = '0;
		c.src = src_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					c.load_in = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				src_d = rau_pkg::SRC_A;
				state_d = stat.zero_den ? S_DONE : S_RLOAD;
			end
			S_RLOAD: begin
				c.red_load = 1'b1;
				state_d = S_GCD;
			end
			S_GCD: begin
				if (stat.gcd_done) begin
					state_d = S_DINIT;
				end else begin
					c.gcd_step = 1'b1;
				end
			end
			S_DINIT: begin
				c.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				c.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				c.red_store = 1'b1;
				case (src_q)
					rau_pkg::SRC_A: begin
						src_d = rau_pkg::SRC_B;
						state_d = S_RLOAD;
					end
					rau_pkg::SRC_B: state_d = S_MUL;
					default: state_d = S_DONE;
				endcase
			end
			S_MUL: begin
				c.mul = 1'b1;
				state_d = S_COMB;
			end
			S_COMB: begin
				c.comb = 1'b1;
				if (stat.arith) begin
					src_d = rau_pkg::SRC_R;
					state_d = S_RLOAD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			src_q <= rau_pkg::SRC_A;
		end else begin
			state_q <= state_d;
			src_q <= src_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/rau_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rau_dp (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire rau_pkg::rau_cmd_t                         c,
	input  wire logic [2:0]                                command,
	input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  a_num,
	input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  a_den,
	input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  b_num,
	input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  b_den,
	output rau_pkg::rau_stat_t                             stat,
	output logic signed [rau_pkg::NUM_W-1:0]               r_num,
	output logic [rau_pkg::DEN_W-1:0]                      r_den,
	output logic                                           r_flag,
	output logic [1:0]                                     r_status
);
	localparam int OW = rau_pkg::OPR_W;
	localparam int MW = rau_pkg::MAG_W;
	localparam int RW = rau_pkg::RED_W;
	localparam int PW = rau_pkg::PROD_W;
	localparam int CW = rau_pkg::CNT_W;

	logic [2:0] cmd_q;
	logic zero_den_q;
	logic signed [OW-1:0] an_q, ad_q, bn_q, bd_q;
	logic neg_q;
	logic [MW-1:0] x_q, y_q, g_q, dvn_q, dvd_q, remn_q, remd_q;
	logic [CW-1:0] k_q, cnt_q;
	logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q;
	logic signed [RW-1:0] pre_n_q, pre_d_q, rnum_q;
	logic [MW-1:0] rden_q;
	logic flag_q;

	logic signed [RW-1:0] src_n, src_d, neg_n, neg_d, qn_ext, qd_ext, store_n, neg_q_n;
	logic [MW-1:0] mag_n, mag_d;
	logic [MW:0] trial_n, trial_d, g_ext;
	logic bit_n, bit_d, div0, arith;
	logic signed [PW-1:0] sum_ab, diff_ab;

	always_comb begin
		case (c.src)
			rau_pkg::SRC_A: begin
				src_n = RW'(an_q);
				src_d = RW'(ad_q);
			end
			rau_pkg::SRC_B: begin
				src_n = RW'(bn_q);
				src_d = RW'(bd_q);
			end
			default: begin
				src_n = pre_n_q;
				src_d = pre_d_q;
			end
		endcase
		neg_n = -src_n;
		neg_d = -src_d;
		mag_n = src_n[RW-1] ? neg_n[MW-1:0] : src_n[MW-1:0];
		mag_d = src_d[RW-1] ? neg_d[MW-1:0] : src_d[MW-1:0];
		g_ext = {1'b0, g_q};
		trial_n = {remn_q, dvn_q[MW-1]};
		trial_d = {remd_q, dvd_q[MW-1]};
		bit_n = trial_n >= g_ext;
		bit_d = trial_d >= g_ext;
		qn_ext = signed'({1'b0, dvn_q});
		qd_ext = signed'({1'b0, dvd_q});
		neg_q_n = -qn_ext;
		store_n = neg_q ? neg_q_n : qn_ext;
		sum_ab = p1_q + p2_q;
		diff_ab = p1_q - p2_q;
		div0 = (cmd_q == rau_pkg::CMD_DIV) && (bn_q == '0);
		arith = (cmd_q == rau_pkg::CMD_ADD) || (cmd_q == rau_pkg::CMD_SUB) ||
			(cmd_q == rau_pkg::CMD_MUL) || ((cmd_q == rau_pkg::CMD_DIV) && !div0);
	end

	assign stat.zero_den = zero_den_q;
	assign stat.gcd_done = (x_q == '0);
	assign stat.div_last = (cnt_q == CW'(MW - 1));
	assign stat.arith = arith;

	always_ff @(posedge clk) begin
		if (c.load_in) begin
			cmd_q <= command;
			an_q <= OW'(a_num);
			ad_q <= OW'(a_den);
			bn_q <= OW'(b_num);
			bd_q <= OW'(b_den);
			zero_den_q <= (a_den == '0) || (b_den == '0);
		end
		if (c.red_load) begin
			neg_q <= src_n[RW-1] ^ src_d[RW-1];
			x_q <= mag_n;
			y_q <= mag_d;
			dvn_q <= mag_n;
			dvd_q <= mag_d;
			k_q <= '0;
		end
		if (c.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + CW'(1);
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
		if (c.div_init) begin
			g_q <= y_q << k_q;
			remn_q <= '0;
			remd_q <= '0;
			cnt_q <= '0;
		end
		if (c.div_step) begin
			remn_q <= bit_n ? MW'(trial_n - g_ext) : trial_n[MW-1:0];
			remd_q <= bit_d ? MW'(trial_d - g_ext) : trial_d[MW-1:0];
			dvn_q <= {dvn_q[MW-2:0], bit_n};
			dvd_q <= {dvd_q[MW-2:0], bit_d};
			cnt_q <= cnt_q + CW'(1);
		end
		if (c.red_store) begin
			case (c.src)
				rau_pkg::SRC_A: begin
					an_q <= store_n[OW-1:0];
					ad_q <= qd_ext[OW-1:0];
				end
				rau_pkg::SRC_B: begin
					bn_q <= store_n[OW-1:0];
					bd_q <= qd_ext[OW-1:0];
				end
				default: begin
					rnum_q <= store_n;
					rden_q <= dvd_q;
				end
			endcase
		end
		if (c.mul) begin
			p1_q <= PW'(an_q) * PW'(bd_q);
			p2_q <= PW'(bn_q) * PW'(ad_q);
			p3_q <= PW'(an_q) * PW'(bn_q);
			p4_q <= PW'(ad_q) * PW'(bd_q);
			p5_q <= PW'(ad_q) * PW'(bn_q);
		end
		if (c.comb) begin
			flag_q <= 1'b0;
			pre_d_q <= RW'(p4_q);
			case (cmd_q)
				rau_pkg::CMD_ADD: pre_n_q <= RW'(sum_ab);
				rau_pkg::CMD_SUB: pre_n_q <= RW'(diff_ab);
				rau_pkg::CMD_MUL: pre_n_q <= RW'(p3_q);
				rau_pkg::CMD_DIV: begin
					pre_n_q <= RW'(p1_q);
					pre_d_q <= RW'(p5_q);
				end
				rau_pkg::CMD_EQ: flag_q <= (an_q == bn_q) && (ad_q == bd_q);
				rau_pkg::CMD_GT: flag_q <= p1_q > p2_q;
				rau_pkg::CMD_LT: flag_q <= p1_q < p2_q;
				default: flag_q <= 1'b0;
			endcase
		end
	end

	always_comb begin
		r_num = '0;
		r_den = '0;
		r_flag = 1'b0;
		r_status = rau_pkg::ST_OK;
		if (zero_den_q) begin
			r_status = rau_pkg::ST_ZDEN;
		end else begin
			if (div0) begin
				r_status = rau_pkg::ST_DIV0;
			end
			if (arith) begin
				r_num = rau_pkg::NUM_W'(rnum_q);
				r_den = rau_pkg::DEN_W'(rden_q);
			end
			r_flag = flag_q;
		end
	end

	`RAU_ASSERT_IMPL(a_div_nonzero, c.div_step, g_q != '0, "divisor is zero")
	`RAU_ASSERT_IMPL(a_den_nonzero, c.red_store, dvd_q != '0, "reduced denominator is zero")
endmodule
`default_nettype wire

@@ rtl/rational_arithmetic_unit.sv @@
// rational arithmetic unit
// input channel: in_valid/in_ready carry command, a_num, a_den, b_num, b_den
// output channel: out_valid/out_ready carry res_num, res_den, compare_true, status
// one item is worked on at a time; in_ready is high only while the unit is idle
// each item: both fractions are reduced, then the result is formed by
// cross-multiplication and, for add/sub/mul and div by a nonzero b, reduced again
// each reduction: load, binary gcd steps (one shift or subtract each),
// a gcd done check, divider init, a restoring divide of numerator and
// denominator by the gcd, and a store
// out_valid rises once the item has passed the check, two reductions (three
// when a result is reduced), the multiply, the combine and the done state;
// in_ready returns in that same cycle
// a zero input denominator goes from the check straight to the done state, status 1
// results sit in an output register; a stalled receiver holds that item and
// the next item still runs, waiting at its end until the register is free
// reset clears the controller and the output valid; no item is in flight after it
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rational_arithmetic_unit (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic [2:0]                               command,
	input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_num,
	input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_den,
	input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_num,
	input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_den,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic signed [rau_pkg::NUM_W-1:0]              res_num,
	output logic [rau_pkg::DEN_W-1:0]                     res_den,
	output logic                                          compare_true,
	output logic [1:0]                                    status
);
	rau_pkg::rau_cmd_t  c;
	rau_pkg::rau_stat_t stat;
	logic out_load, out_free;
	logic signed [rau_pkg::NUM_W-1:0] r_num;
	logic [rau_pkg::DEN_W-1:0] r_den;
	logic r_flag;
	logic [1:0] r_status;
	logic out_valid_q;
	logic err_item, err_clean;

	assign out_free = !out_valid_q || out_ready;

	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.stat     (stat),
		.c        (c),
		.in_ready (in_ready),
		.out_load (out_load)
	);

	rau_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.c        (c),
		.command  (command),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.stat     (stat),
		.r_num    (r_num),
		.r_den    (r_den),
		.r_flag   (r_flag),
		.r_status (r_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_num <= r_num;
			res_den <= r_den;
			compare_true <= r_flag;
			status <= r_status;
		end
	end

	assign out_valid = out_valid_q;

	assign err_item = out_valid && (status != rau_pkg::ST_OK);
	assign err_clean = (res_num == '0) && (res_den == '0) && !compare_true;

	`RAU_ASSERT_IMPL(a_err_zero, err_item, err_clean, "error item has nonzero fields")
	`RAU_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
endmodule
`default_nettype wire

@@ verif/tb_rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
	localparam logic [2:0] CMD_NONE = 3'd7;
	localparam int         WATCHDOG_LIMIT = 8000;
	localparam int         DRAIN_CYCLES = 500;

	typedef logic signed [rau_pkg::OPERAND_WIDTH-1:0] opr_t;

	typedef struct {
		logic signed [rau_pkg::NUM_W-1:0] num;
		logic [rau_pkg::DEN_W-1:0]        den;
		logic                             flag;
		logic [1:0]                       st;
	} ratio_result_t;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_ready;
	logic [2:0]                       command;
	opr_t                             a_num, a_den, b_num, b_den;
	logic                             out_valid;
	logic                             out_ready;
	logic signed [rau_pkg::NUM_W-1:0] res_num;
	logic [rau_pkg::DEN_W-1:0]        res_den;
	logic                             compare_true;
	logic [1:0]                       status;

	ratio_result_t expected_results[$];
	int            mismatches = 0;
	int            hold_left = 0;
	int            idle_cycles = 0;
	bit            busy_phase = 0;

	rational_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_num(res_num), .res_den(res_den),
		.compare_true(compare_true), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic void lowest_terms(inout longint n, inout longint d);
		bit              neg;
		longint unsigned mn, md, g;
		neg = (n < 0) != (d < 0);
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		g = gcd_of(mn, md);
		mn = mn / g;
		md = md / g;
		n = neg ? -longint'(mn) : longint'(mn);
		d = longint'(md);
	endfunction

	function automatic ratio_result_t rational_result(logic [2:0] cmd, opr_t an_i, opr_t ad_i,
			opr_t bn_i, opr_t bd_i);
		ratio_result_t r;
		longint        an, ad, bn, bd, rn, rd;
		bit            arith;
		r = '{num: '0, den: '0, flag: 1'b0, st: rau_pkg::ST_OK};
		an = an_i;
		ad = ad_i;
		bn = bn_i;
		bd = bd_i;
		arith = 0;
		if (ad == 0 || bd == 0) begin
			r.st = rau_pkg::ST_ZDEN;
			return r;
		end
		lowest_terms(an, ad);
		lowest_terms(bn, bd);
		case (cmd)
			rau_pkg::CMD_ADD: begin
				rn = an * bd + bn * ad; rd = ad * bd; arith = 1;
			end
			rau_pkg::CMD_SUB: begin
				rn = an * bd - bn * ad; rd = ad * bd; arith = 1;
			end
			rau_pkg::CMD_MUL: begin
				rn = an * bn; rd = ad * bd; arith = 1;
			end
			rau_pkg::CMD_DIV: begin
				if (bn == 0) r.st = rau_pkg::ST_DIV0;
				else begin
					rn = an * bd; rd = ad * bn; arith = 1;
				end
			end
			rau_pkg::CMD_EQ: r.flag = (an == bn && ad == bd);
			rau_pkg::CMD_GT: r.flag = (an * bd > bn * ad);
			rau_pkg::CMD_LT: r.flag = (an * bd < bn * ad);
			default: ;
		endcase
		if (arith) begin
			lowest_terms(rn, rd);
			r.num = rn[rau_pkg::NUM_W-1:0];
			r.den = rd[rau_pkg::DEN_W-1:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch in %s: got %0d, expected %0d", field, got, want);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		ratio_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result item count", 1, 0);
			end else begin
				e = expected_results.pop_front();
				if (res_num !== e.num) report_mismatch("res_num", res_num, e.num);
				if (res_den !== e.den) report_mismatch("res_den", res_den, e.den);
				if (compare_true !== e.flag)
					report_mismatch("compare_true", compare_true, e.flag);
				if (status !== e.st) report_mismatch("status", status, e.st);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (busy_phase || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	// receiver
	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = gap_len();
			end
		end
	end

	task automatic send_item(logic [2:0] cmd, opr_t an, opr_t ad, opr_t bn, opr_t bd);
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(rational_result(cmd, an, ad, bn, bd));
	endtask

	task automatic sender_gap(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic opr_t rand_opr(bit nonzero);
		opr_t v;
		int   r;
		r = $urandom_range(0, 9);
		if (r < 2) begin
			case ($urandom_range(0, 4))
				0: v = 16'sh8000;
				1: v = 16'sh7fff;
				2: v = 16'sd1;
				3: v = -16'sd1;
				default: v = 16'sd0;
			endcase
		end else if (r < 6) v = opr_t'($urandom_range(0, 48)) - 16'sd24;
		else if (r < 8) v = opr_t'($urandom_range(0, 4096)) * opr_t'($urandom_range(0, 7));
		else v = opr_t'($urandom);
		if (nonzero && v == 0) v = 16'sd1 + opr_t'($urandom_range(0, 5));
		return v;
	endfunction

	task automatic test_directed();
		logic [2:0] c;
		send_item(rau_pkg::CMD_ADD, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send_item(rau_pkg::CMD_SUB, 16'sh8000, 16'sd1, 16'sh7fff, 16'sd1);
		send_item(rau_pkg::CMD_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
		send_item(rau_pkg::CMD_DIV, 16'sd1, 16'sh8000, 16'sd1, 16'sh7fff);
		send_item(rau_pkg::CMD_DIV, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		send_item(rau_pkg::CMD_SUB, 16'sd3, 16'sd6, 16'sd2, 16'sd4);
		send_item(rau_pkg::CMD_ADD, 16'sd0, 16'sd0, 16'sd1, 16'sd1);
		send_item(rau_pkg::CMD_EQ, 16'sd1, 16'sd2, 16'sd1, 16'sd0);
		send_item(rau_pkg::CMD_DIV, 16'sd5, 16'sd3, 16'sd0, -16'sd7);
		send_item(rau_pkg::CMD_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd3);
		send_item(rau_pkg::CMD_EQ, 16'sd2, -16'sd4, -16'sd1, 16'sd2);
		send_item(rau_pkg::CMD_GT, 16'sh7fff, 16'sh8000, -16'sd1, 16'sd1);
		send_item(rau_pkg::CMD_LT, 16'sh8000, 16'sh7fff, -16'sd1, 16'sd1);
		send_item(CMD_NONE, 16'sd3, 16'sd4, 16'sd5, 16'sd6);
		send_item(CMD_NONE, 16'sd3, 16'sd0, 16'sd5, 16'sd6);
		send_item(rau_pkg::CMD_MUL, 16'sd0, -16'sd5, 16'sh7fff, 16'sh8000);
		for (int i = 0; i < 8; i++) begin
			c = 3'(i);
			send_item(c, 16'shffff, 16'shffff, 16'sh5555, 16'sh2aaa);
		end
		sender_gap(1);
	endtask

	task automatic test_random(int n);
		int   r;
		opr_t ad, bd, bn;
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0) busy_phase = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			ad = rand_opr(r >= 4);
			bd = rand_opr(r < 2 || r >= 4);
			bn = (r >= 4 && r < 12) ? 16'sd0 : rand_opr(0);
			send_item(($urandom_range(0, 49) == 0) ? CMD_NONE : 3'($urandom_range(0, 6)),
				rand_opr(0), ad, bn, bd);
			sender_gap(gap_len());
		end
		busy_phase = 0;
	endtask

	task automatic test_output_stall();
		hold_left = 1500;
		for (int i = 0; i < 6; i++)
			send_item(3'($urandom_range(0, 6)), rand_opr(0), rand_opr(1), rand_opr(0),
				rand_opr(1));
		sender_gap(1);
	endtask

	task automatic test_drain_pause();
		sender_gap(1);
		wait (expected_results.size() == 0);
		repeat (5) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = rau_pkg::CMD_ADD;
		a_num = '0;
		a_den = '0;
		b_num = '0;
		b_den = '0;
		clk = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_output_stall();
		test_drain_pause();
		test_random(800);
		test_drain_pause();
		test_output_stall();
		test_random(800);

		sender_gap(1);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
